/* hdl/ttor_pkg.sv */
// Shared types and codes for the timer table block.
package ttor_pkg;

  // Action codes of an input word
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FIRED   = 3'd1;
  localparam logic [2:0] KIND_REMOVED = 3'd2;
  localparam logic [2:0] KIND_DELAY   = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;
  localparam logic [2:0] KIND_DONE    = 3'd5;

  // Configuration register indexes
  localparam logic CFG_IDLE_DELAY = 1'b0;
  localparam logic CFG_BUSY_DELAY = 1'b1;

  // Reset values of the delay caps
  localparam logic [15:0] IDLE_DELAY_RST = 16'd60;
  localparam logic [15:0] BUSY_DELAY_RST = 16'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_value;
    logic [31:0] interval;
    logic        recurring;
    logic [15:0] handler_tag;
    logic [31:0] timer_id;
    logic        queue_pending;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id_out;
    logic [15:0] tag_out;
    logic        found;
    logic [15:0] delay;
    logic        last;
  } out_word_t;

  // One table slot
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [31:0] interval;
    logic        recurring;
    logic [15:0] tag;
  } entry_t;

  // Request to the shared slot unit
  typedef struct packed {
    logic [1:0]  action;
    entry_t      entry;
    logic [31:0] time_value;
    logic [31:0] timer_id;
    logic [15:0] lowest;
    logic        hit;
  } alu_req_t;

  // Answer of the shared slot unit
  typedef struct packed {
    logic        fire;
    logic        keep;
    entry_t      wr_entry;
    logic [15:0] lowest;
    logic        hit;
  } alu_res_t;

endpackage

/* hdl/ttor_mem.sv */
// Timer table storage: one write port, one registered read port.
module ttor_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ttor_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output ttor_pkg::entry_t rdata
);

  ttor_pkg::entry_t mem [DEPTH];
  ttor_pkg::entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ttor_alu.sv */
// Shared slot unit: fire test, deadline advance, id match and delay minimum.
module ttor_alu (
  input  ttor_pkg::alu_req_t req,
  output ttor_pkg::alu_res_t res
);

  logic [31:0] dl;
  logic        fire;
  logic        match;
  logic [31:0] new_dl;
  logic [31:0] cur;
  logic        dropped;

  always_comb begin
    dl     = req.entry.deadline;
    // Tick: armed and due
    fire   = (req.action == ttor_pkg::ACT_TICK) && (dl != 32'd0) && (dl <= req.time_value);
    new_dl = (fire && req.entry.recurring) ? dl + req.entry.interval : dl;
    // Remove: first matching id only
    match  = (req.action == ttor_pkg::ACT_REMOVE) && !req.hit && (req.entry.id == req.timer_id);
    // Query: overdue counts as zero
    cur    = (dl > req.time_value) ? dl - req.time_value : 32'd0;

    dropped = 1'b0;
    case (req.action)
      ttor_pkg::ACT_TICK:   dropped = (fire && !req.entry.recurring) || (new_dl == 32'd0);
      ttor_pkg::ACT_REMOVE: dropped = match;
      default:              dropped = 1'b0;
    endcase

    res                   = '0;
    res.fire              = fire;
    res.keep              = !dropped;
    res.wr_entry          = req.entry;
    res.wr_entry.deadline = new_dl;
    res.hit               = req.hit | match;
    res.lowest            = req.lowest;
    if ((req.action == ttor_pkg::ACT_QUERY) && (cur < {16'd0, req.lowest})) begin
      res.lowest = cur[15:0];
    end
  end

endmodule

/* hdl/timer_table_one_shot_recurring.sv */
// Top level: ordered timer table walked slot by slot under a small sequencer.
//
//  channel | ports                              | word
//  --------+------------------------------------+-----------------------------
//  input   | in_valid, in_stall, in_word        | add / remove / tick / query
//  result  | out_valid, out_stall, out_word     | added, fired, removed, ...
//  config  | cfg_we, cfg_idx, cfg_data          | idle and busy delay caps
//
// Add is accepted, then its result is written into the output register.
// Remove, tick and query walk the n timers held one slot per cycle while no fired
// word waits, through the single table read port and the shared slot unit.
// Each fired word and each final word waits while the output register is full
// and stalled; the block takes no new word until the last result is issued.
// Synchronous reset empties the table by its fill count, clears the id counter
// and loads the caps with 60 and 2; there is no clearing pass.
module timer_table_one_shot_recurring #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ttor_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ttor_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [15:0]         cfg_data
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  ttor_pkg::in_word_t  item_r, item_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic                hit_r, hit_nxt;
  logic [15:0]         lowest_r, lowest_nxt;
  logic [31:0]         id_cnt_r, id_cnt_nxt;
  logic [15:0]         idle_r, idle_nxt;
  logic [15:0]         busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  ttor_pkg::out_word_t out_word_r, out_word_nxt;

  logic                accept;
  logic                out_free;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  ttor_pkg::entry_t    mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  ttor_pkg::entry_t    mem_rdata;
  ttor_pkg::alu_req_t  alu_req;
  ttor_pkg::alu_res_t  alu_res;
  logic                store;
  logic [CW-1:0]       wr_inc;
  logic [CW-1:0]       rd_inc;

  ttor_mem #(
    .DEPTH (TIMER_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttor_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Slot unit sees the slot just read
  always_comb begin
    alu_req            = '0;
    alu_req.action     = item_r.action;
    alu_req.entry      = mem_rdata;
    alu_req.time_value = item_r.time_value;
    alu_req.timer_id   = item_r.timer_id;
    alu_req.lowest     = lowest_r;
    alu_req.hit        = hit_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    n_nxt         = n_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    hit_nxt       = hit_r;
    lowest_nxt    = lowest_r;
    id_cnt_nxt    = id_cnt_r;
    idle_nxt      = idle_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_r[AW-1:0];
    mem_wdata     = alu_res.wr_entry;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    store         = alu_res.keep && (item_r.action != ttor_pkg::ACT_QUERY);
    wr_inc        = store ? wr_r + 1'b1 : wr_r;
    rd_inc        = rd_r + 1'b1;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_idx)
        ttor_pkg::CFG_IDLE_DELAY: idle_nxt = cfg_data;
        ttor_pkg::CFG_BUSY_DELAY: busy_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt   = in_word;
          rd_nxt     = '0;
          wr_nxt     = '0;
          hit_nxt    = 1'b0;
          lowest_nxt = in_word.queue_pending ? busy_r : idle_r;
          mem_re     = 1'b1;
          if ((in_word.action == ttor_pkg::ACT_ADD) || (n_r == '0)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // A due timer waits for room in the output register
        if (!alu_res.fire || out_free) begin
          if (alu_res.fire) begin
            out_valid_nxt        = 1'b1;
            out_word_nxt         = '0;
            out_word_nxt.kind    = ttor_pkg::KIND_FIRED;
            out_word_nxt.id_out  = mem_rdata.id;
            out_word_nxt.tag_out = mem_rdata.tag;
          end
          mem_we     = store;
          wr_nxt     = wr_inc;
          hit_nxt    = alu_res.hit;
          lowest_nxt = alu_res.lowest;
          rd_nxt     = rd_inc;
          if (rd_inc < n_r) begin
            mem_re    = 1'b1;
            mem_raddr = rd_inc[AW-1:0];
          end else begin
            state_nxt = S_FINISH;
            if (item_r.action != ttor_pkg::ACT_QUERY) begin
              n_nxt = wr_inc;
            end
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_word_nxt      = '0;
          out_word_nxt.last = 1'b1;
          case (item_r.action)
            ttor_pkg::ACT_ADD: begin
              if (n_r == CW'(TIMER_SLOTS)) begin
                out_word_nxt.kind = ttor_pkg::KIND_FULL;
              end else begin
                out_word_nxt.kind   = ttor_pkg::KIND_ADDED;
                out_word_nxt.id_out = id_cnt_r + 32'd1;
                id_cnt_nxt          = id_cnt_r + 32'd1;
                mem_we              = 1'b1;
                mem_waddr           = n_r[AW-1:0];
                mem_wdata.id        = id_cnt_r + 32'd1;
                mem_wdata.deadline  = item_r.time_value;
                mem_wdata.interval  = item_r.interval;
                mem_wdata.recurring = item_r.recurring;
                mem_wdata.tag       = item_r.handler_tag;
                n_nxt               = n_r + 1'b1;
              end
            end
            ttor_pkg::ACT_REMOVE: begin
              out_word_nxt.kind   = ttor_pkg::KIND_REMOVED;
              out_word_nxt.id_out = item_r.timer_id;
              out_word_nxt.found  = hit_r;
            end
            ttor_pkg::ACT_TICK: begin
              out_word_nxt.kind = ttor_pkg::KIND_DONE;
            end
            default: begin
              out_word_nxt.kind  = ttor_pkg::KIND_DELAY;
              out_word_nxt.delay = lowest_r;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      id_cnt_r    <= '0;
      idle_r      <= ttor_pkg::IDLE_DELAY_RST;
      busy_r      <= ttor_pkg::BUSY_DELAY_RST;
      out_valid_r <= 1'b0;
      rd_r        <= '0;
      wr_r        <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      id_cnt_r    <= id_cnt_nxt;
      idle_r      <= idle_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      hit_r       <= hit_nxt;
    end
    item_r     <= item_nxt;
    lowest_r   <= lowest_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

/* hdl/ttor_chk.sv */
// Port checker for the timer table, bound to the top level.
module ttor_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ttor_pkg::out_word_t out_word
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  // Only fired words are not last
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.kind == ttor_pkg::KIND_FIRED) != out_word.last))
    else $error("last flag disagrees with kind");

  // Delay field is used by query results only
  a_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind != ttor_pkg::KIND_DELAY) |-> (out_word.delay == 16'd0))
    else $error("delay set on a non-delay result");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timer_table_one_shot_recurring ttor_chk u_ttor_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* sim/tb_timer_table_one_shot_recurring.sv */
// Self-checking testbench for the timer table: predicted result words against the block.
module tb_timer_table_one_shot_recurring;

  localparam int TABLE_SLOTS = 16;
  localparam int LONG_HOLD   = 400;

  // Tracks the timer table as the block should hold it and the result words still owed
  class timer_outcome_book;
    ttor_pkg::entry_t    slot [TABLE_SLOTS];
    int unsigned         fill;
    logic [31:0]         id_count;
    logic [15:0]         idle_cap;
    logic [15:0]         busy_cap;
    ttor_pkg::out_word_t owed [$];
    int unsigned         faults;

    function new();
      fill     = 0;
      id_count = '0;
      idle_cap = ttor_pkg::IDLE_DELAY_RST;
      busy_cap = ttor_pkg::BUSY_DELAY_RST;
      faults   = 0;
    endfunction

    function void queue_result(logic [2:0] kind, logic [31:0] id, logic [15:0] tag,
                               logic found, logic [15:0] delay, logic last);
      ttor_pkg::out_word_t r;
      r.kind    = kind;
      r.id_out  = id;
      r.tag_out = tag;
      r.found   = found;
      r.delay   = delay;
      r.last    = last;
      owed.push_back(r);
    endfunction

    // Remove one slot and shift the younger timers down
    function void close_gap(int unsigned pos);
      for (int unsigned j = pos; j + 1 < fill; j++) slot[j] = slot[j + 1];
      fill--;
    endfunction

    // Work out the result words of one accepted input word
    function void note_word(ttor_pkg::in_word_t w);
      int unsigned i;
      logic        gone;
      logic        hit;
      logic [31:0] dl;
      logic [31:0] cur;
      logic [31:0] lowest;
      case (w.action)
        ttor_pkg::ACT_ADD: begin
          if (fill >= TABLE_SLOTS) begin
            queue_result(ttor_pkg::KIND_FULL, '0, '0, 1'b0, '0, 1'b1);
          end else begin
            id_count = id_count + 32'd1;
            slot[fill].id        = id_count;
            slot[fill].deadline  = w.time_value;
            slot[fill].interval  = w.interval;
            slot[fill].recurring = w.recurring;
            slot[fill].tag       = w.handler_tag;
            fill++;
            queue_result(ttor_pkg::KIND_ADDED, id_count, '0, 1'b0, '0, 1'b1);
          end
        end
        ttor_pkg::ACT_REMOVE: begin
          hit = 1'b0;
          i   = 0;
          while (!hit && i < fill) begin
            if (slot[i].id == w.timer_id) begin
              close_gap(i);
              hit = 1'b1;
            end else begin
              i++;
            end
          end
          queue_result(ttor_pkg::KIND_REMOVED, w.timer_id, '0, hit, '0, 1'b1);
        end
        ttor_pkg::ACT_TICK: begin
          i = 0;
          while (i < fill) begin
            gone = 1'b0;
            dl   = slot[i].deadline;
            if (dl != 0 && dl <= w.time_value) begin
              queue_result(ttor_pkg::KIND_FIRED, slot[i].id, slot[i].tag, 1'b0, '0, 1'b0);
              if (slot[i].recurring) slot[i].deadline = dl + slot[i].interval;
              else gone = 1'b1;
            end
            // zero deadline: a stored one is dropped unfired, one reached by wrapping after firing
            if (!gone && slot[i].deadline == 0) gone = 1'b1;
            if (gone) close_gap(i);
            else i++;
          end
          queue_result(ttor_pkg::KIND_DONE, '0, '0, 1'b0, '0, 1'b1);
        end
        default: begin
          lowest = {16'd0, (w.queue_pending ? busy_cap : idle_cap)};
          for (int unsigned j = 0; j < fill; j++) begin
            dl  = slot[j].deadline;
            cur = (dl > w.time_value) ? dl - w.time_value : 32'd0;  // overdue counts as 0
            if (cur < lowest) lowest = cur;
          end
          queue_result(ttor_pkg::KIND_DELAY, '0, '0, 1'b0, lowest[15:0], 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        faults++;
      end
    endfunction

    function void check_word(ttor_pkg::out_word_t got);
      ttor_pkg::out_word_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing owed: kind %0d id %0h", got.kind, got.id_out);
        faults++;
        return;
      end
      want = owed.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("id_out", want.id_out, got.id_out);
      compare_field("tag_out", 32'(want.tag_out), 32'(got.tag_out));
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("delay", 32'(want.delay), 32'(got.delay));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ttor_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  ttor_pkg::out_word_t out_word;
  logic                cfg_we;
  logic                cfg_idx;
  logic [15:0]         cfg_data;

  timer_outcome_book book = new();
  logic [31:0] now;          // notional current time for well-formed sequences
  bit          quiet;        // no idling on either side while set
  bit          hold_request; // asks the result side for one long hold-off
  int unsigned wait_left;

  always #5 clk = ~clk;

  timer_table_one_shot_recurring #(.TIMER_SLOTS(TABLE_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned pick_wait();
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // Result side: take a word, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      book.check_word(out_word);
      wait_left = pick_wait();
    end
    if (hold_request) begin
      wait_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (wait_left > 0) begin
      out_stall <= 1'b1;
      wait_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word after a gap; returns at the edge that takes it
  task automatic send_word(ttor_pkg::in_word_t w, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.note_word(w);
  endtask

  task automatic send_fields(logic [1:0] act, logic [31:0] tv, logic [31:0] iv, logic rec,
                             logic [15:0] tag, logic [31:0] tid, logic pend);
    ttor_pkg::in_word_t w;
    w.action        = act;
    w.time_value    = tv;
    w.interval      = iv;
    w.recurring     = rec;
    w.handler_tag   = tag;
    w.timer_id      = tid;
    w.queue_pending = pend;
    send_word(w, pick_wait());
  endtask

  // Sender pauses until every owed result word has been taken
  task automatic await_results();
    in_valid <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_caps(logic [15:0] idle, logic [15:0] busy);
    cfg_we   <= 1'b1;
    cfg_idx  <= ttor_pkg::CFG_IDLE_DELAY;
    cfg_data <= idle;
    @(posedge clk);
    book.idle_cap = idle;
    cfg_idx  <= ttor_pkg::CFG_BUSY_DELAY;
    cfg_data <= busy;
    @(posedge clk);
    book.busy_cap = busy;
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic around the notional time, some noise
  function automatic ttor_pkg::in_word_t make_word();
    ttor_pkg::in_word_t w;
    int unsigned        pick;
    w.time_value    = $urandom();
    w.interval      = $urandom();
    w.recurring     = 1'($urandom_range(0, 1));
    w.handler_tag   = 16'($urandom_range(0, 16'hFFFF));
    w.timer_id      = $urandom();
    w.queue_pending = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.action = ttor_pkg::ACT_ADD;
      case ($urandom_range(0, 9))
        0:       w.time_value = 32'd0;
        1:       ;
        2:       w.time_value = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: w.time_value = now + $urandom_range(0, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       w.interval = 32'd0;
        1:       ;
        2:       w.interval = 32'hFFFF_FFFF;
        default: w.interval = $urandom_range(1, 12);
      endcase
    end else if (pick < 50) begin
      w.action = ttor_pkg::ACT_REMOVE;
      pick = $urandom_range(0, 9);
      if (book.fill > 0 && pick < 7) w.timer_id = book.slot[$urandom_range(0, book.fill - 1)].id;
      else if (pick == 7) w.timer_id = 32'd0;
      else if (pick == 8) w.timer_id = book.id_count + 32'd1;
    end else if (pick < 80) begin
      w.action = ttor_pkg::ACT_TICK;
      pick = $urandom_range(0, 19);
      if (pick == 0) w.time_value = 32'hFFFF_FFFF;
      else if (pick > 2) begin
        now = now + $urandom_range(0, 6);
        w.time_value = now;
      end
    end else begin
      w.action = ttor_pkg::ACT_QUERY;
      if ($urandom_range(0, 4) != 0) w.time_value = now + $urandom_range(0, 10);
    end
    return w;
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_word(make_word(), pick_wait());
  endtask

  // Back-to-back adds with far deadlines, enough to overflow the table
  task automatic fill_table(int unsigned count);
    ttor_pkg::in_word_t w;
    repeat (count) begin
      w               = make_word();
      w.action        = ttor_pkg::ACT_ADD;
      w.time_value    = now + $urandom_range(30, 200);
      w.recurring     = 1'b0;
      send_word(w, 0);
    end
  endtask

  // Run limit, several times the slowest legal run
  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = ttor_pkg::CFG_IDLE_DELAY;
    cfg_data  = '0;
    now       = 32'd100;
    quiet     = 1'b0;
    hold_request = 1'b0;
    wait_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table caps, zero and wrapping deadlines, overdue, remove hit and miss
    send_fields(ttor_pkg::ACT_QUERY, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_fields(ttor_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0, 32'd0, 1'b1);
    send_fields(ttor_pkg::ACT_ADD, 32'd0, 32'd7, 1'b0, 16'd0, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_ADD, 32'd5, 32'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_fields(ttor_pkg::ACT_ADD, 32'd5, 32'hFFFF_FFFF, 1'b1, 16'h00A5, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_ADD, 32'd1, 32'hFFFF_FFFF, 1'b1, 16'h5A00, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd3, 1'b1, 16'h1234, 32'd0, 1'b1);
    send_fields(ttor_pkg::ACT_QUERY, 32'd3, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_REMOVE, 32'd0, 32'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 1'b0);
    send_fields(ttor_pkg::ACT_TICK, 32'd5, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'd2, 1'b1);
    send_fields(ttor_pkg::ACT_QUERY, 32'd10, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_REMOVE, 32'd0, 32'd0, 1'b0, 16'd0, 32'd5, 1'b0);
    send_fields(ttor_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    send_fields(ttor_pkg::ACT_QUERY, 32'd1, 32'd0, 1'b0, 16'd0, 32'd0, 1'b1);
    send_fields(ttor_pkg::ACT_REMOVE, 32'd0, 32'd0, 1'b0, 16'd0, 32'd3, 1'b0);
    send_fields(ttor_pkg::ACT_REMOVE, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    await_results();

    // Both caps at zero
    write_caps(16'd0, 16'd0);
    run_random(35);
    await_results();

    // Both caps at maximum; result side holds off while the table overflows
    write_caps(16'hFFFF, 16'hFFFF);
    hold_request = 1'b1;
    fill_table(18);
    run_random(35);
    await_results();

    // Random caps, no idling on either side
    write_caps(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    quiet = 1'b1;
    run_random(35);
    quiet = 1'b0;
    await_results();

    write_caps(16'd1, 16'hFFFE);
    run_random(35);

    await_results();
    repeat (40) @(posedge clk);
    if (book.owed.size() != 0) begin
      $error("%0d result words never arrived", book.owed.size());
      book.faults++;
    end
    if (book.faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
